// ===== src/stpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: shared package
// Field widths, mode and register codes, FSM states and the
// controller/datapath command and status words.
// ----------------------------------------------------------------------------
package stpc_pkg;

    localparam int MAX_PORTS_DEF = 16;
    localparam int ADDR_BITS_DEF = 16;

    localparam int MODE_W    = 2;
    localparam int PORT_W    = 5;
    localparam int PATH_W    = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_HELLO = 2'd0,
        MODE_FLOOD = 2'd1,
        MODE_START = 2'd2
    } t_mode;

    localparam logic KIND_HELLO = 1'b0;
    localparam logic KIND_FLOOD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT  = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture input word, issue neighbor table read
        logic exec;   // apply the word to the view, build the send mask
        logic emit;   // load one packet into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;     // send mask is all clear
        logic hit;       // send mask bit at the scan index
        logic out_free;  // output register can take a word this cycle
    } t_sts;

    function automatic int cfg_w(input int addr_bits);
        return (addr_bits > PORT_W) ? addr_bits : PORT_W;
    endfunction

endpackage

// ===== src/stpc_in_if.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: input channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface stpc_in_if #(
    parameter int ADDR_BITS = stpc_pkg::ADDR_BITS_DEF
);
    import stpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [PORT_W-1:0]    arrival_port;
    logic [ADDR_BITS-1:0] adv_root;
    logic [PATH_W-1:0]    adv_path;
    logic [ADDR_BITS-1:0] adv_sender;

    modport source (
        output valid, mode, arrival_port, adv_root, adv_path, adv_sender,
        input  ready
    );

    modport sink (
        input  valid, mode, arrival_port, adv_root, adv_path, adv_sender,
        output ready
    );

endinterface

// ===== src/stpc_out_if.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: output channel
// Valid/ready channel carrying one packet word.
// ----------------------------------------------------------------------------
interface stpc_out_if #(
    parameter int ADDR_BITS = stpc_pkg::ADDR_BITS_DEF
);
    import stpc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PORT_W-1:0]    out_port;
    logic                 pkt_kind;
    logic [ADDR_BITS-1:0] pkt_root;
    logic [PATH_W-1:0]    pkt_path;
    logic [ADDR_BITS-1:0] pkt_sender;
    logic                 last;

    modport source (
        output valid, out_port, pkt_kind, pkt_root, pkt_path, pkt_sender, last,
        input  ready
    );

    modport sink (
        input  valid, out_port, pkt_kind, pkt_root, pkt_path, pkt_sender, last,
        output ready
    );

endinterface

// ===== src/stpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: controller
// Sequences accept, execute and the port scan that sends packets.
// ----------------------------------------------------------------------------
module stpc_ctrl #(
    parameter int MAX_PORTS = stpc_pkg::MAX_PORTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  stpc_pkg::t_sts                   i_sts,
    output stpc_pkg::t_cmd                   o_cmd,
    output logic [$clog2(MAX_PORTS+1)-1:0]   o_idx
);
    import stpc_pkg::*;

    localparam int IW = $clog2(MAX_PORTS + 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx,   n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_idx      = '0;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.empty) begin
                    n_state = ST_IDLE;
                end else if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        n_idx      = r_idx + IW'(1);
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_idx = r_idx;

endmodule

// ===== src/stpc_dp.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: datapath
// Config registers, tree view, neighbor table, send mask, output register.
// ----------------------------------------------------------------------------
module stpc_dp #(
    parameter int MAX_PORTS = stpc_pkg::MAX_PORTS_DEF,
    parameter int ADDR_BITS = stpc_pkg::ADDR_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [stpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [stpc_pkg::cfg_w(ADDR_BITS)-1:0]  i_cfg_data,
    input  stpc_pkg::t_cmd                         i_cmd,
    input  logic [$clog2(MAX_PORTS+1)-1:0]         i_idx,
    output stpc_pkg::t_sts                         o_sts,
    input  logic [stpc_pkg::MODE_W-1:0]            i_mode,
    input  logic [stpc_pkg::PORT_W-1:0]            i_arrival_port,
    input  logic [ADDR_BITS-1:0]                   i_adv_root,
    input  logic [stpc_pkg::PATH_W-1:0]            i_adv_path,
    input  logic [ADDR_BITS-1:0]                   i_adv_sender,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [stpc_pkg::PORT_W-1:0]            o_out_port,
    output logic                                   o_pkt_kind,
    output logic [ADDR_BITS-1:0]                   o_pkt_root,
    output logic [stpc_pkg::PATH_W-1:0]            o_pkt_path,
    output logic [ADDR_BITS-1:0]                   o_pkt_sender,
    output logic                                   o_last
);
    import stpc_pkg::*;

    localparam int IW = $clog2(MAX_PORTS + 1);
    localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int EW = (IW > PORT_W) ? IW : PORT_W;
    localparam int NP = MAX_PORTS + 1;
    localparam logic [ADDR_BITS-1:0] INVALID_ADDR = {ADDR_BITS{1'b1}};

    // config
    logic [ADDR_BITS-1:0] r_own;
    logic [PORT_W-1:0]    r_pcnt;

    // captured request
    logic [MODE_W-1:0]    r_mode;
    logic [PORT_W-1:0]    r_port;
    logic [ADDR_BITS-1:0] r_root;
    logic [PATH_W-1:0]    r_path;
    logic [ADDR_BITS-1:0] r_sender;

    // tree view
    logic [ADDR_BITS-1:0] r_best;
    logic [PATH_W-1:0]    r_dist;
    logic [ADDR_BITS-1:0] r_parent;
    logic [MAX_PORTS-1:0] r_blk;

    // neighbor table, valid bits stand in for the reset fill
    logic [ADDR_BITS-1:0] mem_nbr [MAX_PORTS];
    logic [MAX_PORTS-1:0] r_vld;
    logic [ADDR_BITS-1:0] r_rd_data;

    // send mask and packet kind for the current word
    logic [NP-1:0]        r_elig;
    logic                 r_kind;

    // output register
    logic                 r_out_valid;
    logic [PORT_W-1:0]    r_out_port;
    logic                 r_out_kind;
    logic [ADDR_BITS-1:0] r_out_root;
    logic [PATH_W-1:0]    r_out_path;
    logic [ADDR_BITS-1:0] r_out_sender;
    logic                 r_out_last;

    logic [IW-1:0]        w_n;
    logic [EW-1:0]        w_n_e;
    logic [EW-1:0]        w_port_e;
    logic [AW-1:0]        w_a;
    logic                 w_port_ok;
    logic [MAX_PORTS-1:0] w_low;
    logic [MAX_PORTS-1:0] w_self;
    logic [NP-1:0]        w_user;
    logic [NP-1:0]        w_flood;
    logic [NP-1:0]        w_hellos;
    logic [NP-1:0]        w_elig_clr;
    logic [PATH_W-1:0]    w_p1;
    logic                 w_learned;
    logic                 w_chg;
    logic [ADDR_BITS-1:0] w_best;
    logic [PATH_W-1:0]    w_dist;
    logic [ADDR_BITS-1:0] w_par;
    logic                 w_block;
    logic                 w_out_free;

    // effective port count, clamped to the table size
    always_comb begin
        if (EW'(r_pcnt) > EW'(MAX_PORTS)) begin
            w_n = IW'(MAX_PORTS);
        end else begin
            w_n = IW'(r_pcnt);
        end
    end

    assign w_n_e     = EW'(w_n);
    assign w_port_e  = EW'(r_port);
    assign w_a       = AW'(r_port);
    assign w_port_ok = w_port_e < w_n_e;

    always_comb begin
        for (int j = 0; j < MAX_PORTS; j++) begin
            w_low[j]  = EW'(j) < w_n_e;
            w_self[j] = w_port_e == EW'(j);
        end
        for (int j = 0; j < NP; j++) begin
            w_user[j] = EW'(j) == w_n_e;
        end
    end

    assign w_hellos = {1'b0, w_low};
    assign w_flood  = {1'b0, w_low & ~r_blk & ~w_self}
                    | ((w_port_e != w_n_e) ? w_user : '0);

    // hello evaluation: root, then path, then sender order
    assign w_p1      = (r_path == {PATH_W{1'b1}}) ? r_path : r_path + PATH_W'(1);
    assign w_learned = r_vld[w_a] && (r_rd_data != INVALID_ADDR);

    always_comb begin
        w_best = r_best;
        w_dist = r_dist;
        w_par  = r_parent;
        w_chg  = 1'b0;
        if (r_root < r_best) begin
            w_best = r_root;
            w_dist = w_p1;
            w_par  = r_sender;
            w_chg  = 1'b1;
        end else if (r_root == r_best && w_p1 < r_dist) begin
            w_dist = w_p1;
            w_par  = r_sender;
            w_chg  = 1'b1;
        end else if (r_root == r_best && w_p1 == r_dist && r_sender < r_parent) begin
            w_par  = r_sender;
            w_chg  = 1'b1;
        end
    end

    // child test without wrap
    assign w_block = !((r_sender == w_par) ||
                       (r_root == w_best &&
                        {1'b0, r_path} == ({1'b0, w_dist} + (PATH_W+1)'(1))));

    always_comb begin
        w_elig_clr = r_elig;
        w_elig_clr[i_idx] = 1'b0;
    end

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own       <= '0;
            r_pcnt      <= '0;
            r_best      <= '0;
            r_dist      <= '0;
            r_parent    <= '0;
            r_blk       <= '0;
            r_vld       <= '0;
            r_elig      <= '0;
            r_kind      <= KIND_HELLO;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_ADDRESS: r_own  <= i_cfg_data[ADDR_BITS-1:0];
                    CFG_PORT_COUNT:  r_pcnt <= i_cfg_data[PORT_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.exec) begin
                r_elig <= '0;
                r_kind <= KIND_HELLO;
                case (t_mode'(r_mode))
                    MODE_HELLO: begin
                        if (w_port_ok) begin
                            r_best     <= w_best;
                            r_dist     <= w_dist;
                            r_parent   <= w_par;
                            r_blk[w_a] <= w_block;
                            if (!w_learned) begin
                                r_vld[w_a] <= 1'b1;
                            end
                            if (w_chg) begin
                                r_elig <= w_hellos;
                            end
                        end
                    end
                    MODE_FLOOD: begin
                        r_elig <= w_flood;
                        r_kind <= KIND_FLOOD;
                    end
                    MODE_START: begin
                        r_best   <= r_own;
                        r_parent <= r_own;
                        r_dist   <= '0;
                        r_blk    <= '0;
                        r_vld    <= '0;
                        r_elig   <= w_hellos;
                    end
                    default: ;
                endcase
            end else if (i_cmd.emit) begin
                r_elig <= w_elig_clr;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_port   <= i_arrival_port;
            r_root   <= i_adv_root;
            r_path   <= i_adv_path;
            r_sender <= i_adv_sender;
        end
        if (i_cmd.emit) begin
            r_out_port   <= PORT_W'(i_idx);
            r_out_kind   <= r_kind;
            r_out_root   <= r_best;
            r_out_path   <= r_dist;
            r_out_sender <= r_own;
            r_out_last   <= (w_elig_clr == '0);
        end
    end

    // neighbor table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_data <= mem_nbr[AW'(i_arrival_port)];
        end
        if (i_cmd.exec && t_mode'(r_mode) == MODE_HELLO && w_port_ok && !w_learned) begin
            mem_nbr[w_a] <= r_sender;
        end
    end

    assign o_sts.empty    = (r_elig == '0);
    assign o_sts.hit      = r_elig[i_idx];
    assign o_sts.out_free = w_out_free;

    assign o_valid      = r_out_valid;
    assign o_out_port   = r_out_port;
    assign o_pkt_kind   = r_out_kind;
    assign o_pkt_root   = r_out_root;
    assign o_pkt_path   = r_out_path;
    assign o_pkt_sender = r_out_sender;
    assign o_last       = r_out_last;

endmodule

// ===== src/spanning_tree_port_control_core.sv =====
// A request word is taken in the idle state and applied in the next cycle, then
//   the port scan sends at most one packet word per cycle while the output
//   register is free. A new request is taken only once the scan over ports
//   0..port count (one position a cycle, held by output stalls) clears the mask.
// Reset (synchronous, active low) clears config, tree view, blocked marks and
//   neighbor valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Spanning-tree port control core
// Root election and per-port open/blocked control for one bridge, sending
// hello and flood packets on the port scan.
// ----------------------------------------------------------------------------
module spanning_tree_port_control_core #(
    parameter int MAX_PORTS = stpc_pkg::MAX_PORTS_DEF,
    parameter int ADDR_BITS = stpc_pkg::ADDR_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [stpc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [stpc_pkg::cfg_w(ADDR_BITS)-1:0]  i_cfg_data,
    stpc_in_if.sink                                i_req,
    stpc_out_if.source                             o_pkt
);
    import stpc_pkg::*;

    localparam int IW = $clog2(MAX_PORTS + 1);

    // Controller and datapath talk only through these words:
    //   cmd.load  - capture the request word and read the neighbor entry
    //   cmd.exec  - update root/path/parent, set the blocked mark,
    //               build the mask of ports to send on
    //   cmd.emit  - move one packet into the output register
    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_idx;
    logic          w_ready;

    assign i_req.ready = w_ready;

    stpc_ctrl #(
        .MAX_PORTS (MAX_PORTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // The send mask has one bit per neighbor port plus one for the user port.
    // The scan walks it from port 0 up; the word that clears the last set bit
    // is flagged last. Packets carry the view as it stands after the update.
    stpc_dp #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .i_idx          (w_idx),
        .o_sts          (w_sts),
        .i_mode         (i_req.mode),
        .i_arrival_port (i_req.arrival_port),
        .i_adv_root     (i_req.adv_root),
        .i_adv_path     (i_req.adv_path),
        .i_adv_sender   (i_req.adv_sender),
        .o_valid        (o_pkt.valid),
        .i_ready        (o_pkt.ready),
        .o_out_port     (o_pkt.out_port),
        .o_pkt_kind     (o_pkt.pkt_kind),
        .o_pkt_root     (o_pkt.pkt_root),
        .o_pkt_path     (o_pkt.pkt_path),
        .o_pkt_sender   (o_pkt.pkt_sender),
        .o_last         (o_pkt.last)
    );

    // Each accepted word is applied in the very next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_cmd.exec)
        else $error("accepted word not applied in next cycle");

    // A new word is only taken once the previous word's sends are all out.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> w_sts.empty)
        else $error("input ready while send mask still pending");

    // An emitted packet shows up on the output in the following cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_pkt.valid)
        else $error("emitted packet missing from output register");

endmodule

// ===== verif/stpc_checker.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control: packet checker
// Watches the config port and both channels, keeps its own copy of the
// tree view, forecasts the packet words of each request and compares them
// in order with what the core sends.
// ----------------------------------------------------------------------------
module stpc_checker
    import stpc_pkg::*;
#(
    parameter int MAX_PORTS = MAX_PORTS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [cfg_w(ADDR_BITS)-1:0]   i_cfg_data,
    stpc_in_if                            i_req,
    stpc_out_if                           i_pkt,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PORT_W-1:0]    port;
        logic                 kind;
        logic [ADDR_BITS-1:0] root;
        logic [PATH_W-1:0]    path;
        logic [ADDR_BITS-1:0] sender;
        logic                 last;
    } t_pkt_word;

    t_pkt_word pkts_due[$];
    t_pkt_word burst[$];

    logic [ADDR_BITS-1:0] own_addr;
    logic [PORT_W-1:0]    port_cnt;
    logic [ADDR_BITS-1:0] best_root;
    logic [PATH_W-1:0]    root_dist;
    logic [ADDR_BITS-1:0] parent_addr;
    logic [ADDR_BITS-1:0] nbr_addr [MAX_PORTS];
    logic                 blocked  [MAX_PORTS];

    initial o_fail_count = 0;

    function automatic int live_ports();
        return (port_cnt > MAX_PORTS) ? MAX_PORTS : int'(port_cnt);
    endfunction

    task automatic queue_pkt(input int port, input logic kind);
        burst.push_back('{port: port[PORT_W-1:0], kind: kind, root: best_root,
                          path: root_dist, sender: own_addr, last: 1'b0});
    endtask

    task automatic hello_all(input int n);
        for (int i = 0; i < n; i++) queue_pkt(i, KIND_HELLO);
    endtask

    task automatic clear_view();
        for (int i = 0; i < MAX_PORTS; i++) begin
            nbr_addr[i] = '1;
            blocked[i]  = 1'b0;
        end
    endtask

    // Update the view for one request word and queue the packets it sends.
    task automatic forecast_burst(
        input logic [MODE_W-1:0]    mode,
        input logic [PORT_W-1:0]    port,
        input logic [ADDR_BITS-1:0] root,
        input logic [PATH_W-1:0]    path,
        input logic [ADDR_BITS-1:0] sender
    );
        int                n;
        logic [PATH_W-1:0] hop;
        logic              moved;
        t_pkt_word         tail;
        n     = live_ports();
        moved = 1'b0;
        burst.delete();
        case (mode)
            MODE_HELLO: begin
                if (port < n) begin
                    hop = (path == '1) ? path : path + 1'b1;
                    if (nbr_addr[port] == '1) begin
                        nbr_addr[port] = sender;
                        blocked[port]  = 1'b0;
                    end
                    if (root < best_root) begin
                        best_root   = root;
                        root_dist   = hop;
                        parent_addr = sender;
                        moved       = 1'b1;
                    end else if (root == best_root && hop < root_dist) begin
                        root_dist   = hop;
                        parent_addr = sender;
                        moved       = 1'b1;
                    end else if (root == best_root && hop == root_dist &&
                                 sender < parent_addr) begin
                        parent_addr = sender;
                        moved       = 1'b1;
                    end
                    if (moved) hello_all(n);
                    // child test is done one bit wider so it cannot wrap
                    if (sender == parent_addr)
                        blocked[port] = 1'b0;
                    else if (root == best_root &&
                             {1'b0, path} == {1'b0, root_dist} + 1'b1)
                        blocked[port] = 1'b0;
                    else
                        blocked[port] = 1'b1;
                end
            end
            MODE_FLOOD: begin
                for (int i = 0; i < n; i++)
                    if (!blocked[i] && i != port) queue_pkt(i, KIND_FLOOD);
                if (port != n) queue_pkt(n, KIND_FLOOD);
            end
            MODE_START: begin
                best_root   = own_addr;
                parent_addr = own_addr;
                root_dist   = '0;
                clear_view();
                hello_all(n);
            end
            default: ;
        endcase
        if (burst.size() > 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i]) pkts_due.push_back(burst[i]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pkt_word want;
        if (!i_rst_n) begin
            own_addr    = '0;
            port_cnt    = '0;
            best_root   = '0;
            root_dist   = '0;
            parent_addr = '0;
            clear_view();
            pkts_due.delete();
        end else begin
            // outputs first: nothing accepted at this edge can show yet
            if (i_pkt.valid && i_pkt.ready) begin
                if (pkts_due.size() == 0) begin
                    $error("unexpected packet word on port %0d", i_pkt.out_port);
                    o_fail_count++;
                end else begin
                    want = pkts_due.pop_front();
                    check_field("out_port", want.port, i_pkt.out_port);
                    check_field("pkt_kind", want.kind, i_pkt.pkt_kind);
                    check_field("pkt_root", want.root, i_pkt.pkt_root);
                    check_field("pkt_path", want.path, i_pkt.pkt_path);
                    check_field("pkt_sender", want.sender, i_pkt.pkt_sender);
                    check_field("last", want.last, i_pkt.last);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OWN_ADDRESS)
                    own_addr = i_cfg_data[ADDR_BITS-1:0];
                else if (i_cfg_idx == CFG_PORT_COUNT)
                    port_cnt = i_cfg_data[PORT_W-1:0];
            end
            if (i_req.valid && i_req.ready)
                forecast_burst(i_req.mode, i_req.arrival_port, i_req.adv_root,
                               i_req.adv_path, i_req.adv_sender);
        end
        o_pending = pkts_due.size();
    end

endmodule

// ===== verif/spanning_tree_port_control_core_tb.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port control core: testbench
// Directed words for root election, path saturation, blocking, flood fan-out
// and odd port counts, then randomized phases of start/hello/flood traffic
// under varied configs, with random stalls on both channels. A separate
// checker forecasts and compares every packet word.
// ----------------------------------------------------------------------------
module spanning_tree_port_control_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stpc_pkg::*;

    localparam int MAX_PORTS = MAX_PORTS_DEF;
    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int CFG_W     = cfg_w(ADDR_BITS);

    // the mode the core has no use for; it must be swallowed silently
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_PERIOD    = 12;
    localparam int IDLE_PCT      = 16;          // chance of a bubble per cycle
    localparam int SETTLE_CYCLES = MAX_PORTS + 8; // one full port scan, padded
    localparam int RANDOM_ITEMS  = 264;
    localparam int PHASE_ITEMS   = 44;
    localparam int CYCLE_LIMIT   = 400_000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    stpc_in_if  #(.ADDR_BITS(ADDR_BITS)) req_ch ();
    stpc_out_if #(.ADDR_BITS(ADDR_BITS)) pkt_ch ();

    int fail_count;
    int pending_words;
    int cycle_count = 0;
    int counted     = 0;   // words that do real work (ignored ones excluded)
    bit calm        = 1'b0; // when set, neither side inserts bubbles

    // stimulus-side copy of the config, used to aim ports at real neighbors
    logic [ADDR_BITS-1:0] cur_own;
    logic [PORT_W-1:0]    cur_ports;
    logic [ADDR_BITS-1:0] root_pool   [3];
    logic [ADDR_BITS-1:0] sender_pool [6];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    spanning_tree_port_control_core #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_pkt      (pkt_ch)
    );

    stpc_checker #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req_ch),
        .i_pkt        (pkt_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    // Packet sink back-pressure: one draw per cycle, none while calm.
    always @(posedge i_clk) begin
        pkt_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: a hang or a missing packet word ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int live_ports();
        return (cur_ports > MAX_PORTS) ? MAX_PORTS : int'(cur_ports);
    endfunction

    // One register write; the trailing edge keeps we from being lowered and
    // raised within one step when writes come back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ADDR_BITS-1:0] own,
                              input logic [PORT_W-1:0] ports);
        write_reg(CFG_OWN_ADDRESS, CFG_W'(own));
        write_reg(CFG_PORT_COUNT, CFG_W'(ports));
        cur_own   = own;
        cur_ports = ports;
    endtask

    // Offer one request word and hold it until taken. Ready is sampled on the
    // falling edge, where everything driven at the rising edge has settled.
    task automatic send_req(input logic [MODE_W-1:0]    mode,
                            input logic [PORT_W-1:0]    port,
                            input logic [ADDR_BITS-1:0] root,
                            input logic [PATH_W-1:0]    path,
                            input logic [ADDR_BITS-1:0] sender);
        bit taken;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.arrival_port <= port;
        req_ch.adv_root     <= root;
        req_ch.adv_path     <= path;
        req_ch.adv_sender   <= sender;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
        if (mode == MODE_START || mode == MODE_FLOOD ||
            (mode == MODE_HELLO && port < live_ports()))
            counted++;
    endtask

    // Let the core go quiet: all forecast words out, then one more scan so a
    // word that sends nothing has also been applied.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random word: mostly hellos drawn from small root/sender pools so that
    // ties on root, path and sender actually happen; some raw noise.
    task automatic random_word();
        logic [MODE_W-1:0]    mode;
        logic [PORT_W-1:0]    port;
        logic [ADDR_BITS-1:0] root;
        logic [PATH_W-1:0]    path;
        logic [ADDR_BITS-1:0] sender;
        int                   n;
        int                   pick;
        n    = live_ports();
        pick = $urandom_range(0, 99);
        if (pick < 6)       mode = MODE_START;
        else if (pick < 9)  mode = MODE_UNUSED;
        else if (pick < 40) mode = MODE_FLOOD;
        else                mode = MODE_HELLO;

        if (n == 0 || $urandom_range(0, 9) == 0)
            port = PORT_W'($urandom_range(0, 31));
        else if (mode == MODE_FLOOD)
            port = PORT_W'($urandom_range(0, n));
        else
            port = PORT_W'($urandom_range(0, n - 1));

        root = ($urandom_range(0, 6) == 0) ? ADDR_BITS'($urandom)
                                           : root_pool[$urandom_range(0, 2)];
        if ($urandom_range(0, 6) == 0)      path = PATH_W'($urandom);
        else if ($urandom_range(0, 9) == 0) path = PATH_W'(16'hFFFF - $urandom_range(0, 1));
        else                                path = PATH_W'($urandom_range(0, 4));
        sender = ($urandom_range(0, 6) == 0) ? ADDR_BITS'($urandom)
                                             : sender_pool[$urandom_range(0, 5)];
        send_req(mode, port, root, path, sender);
    endtask

    initial begin
        int phase;
        int phase_base;
        logic [ADDR_BITS-1:0] own;
        logic [PORT_W-1:0]    ports;

        req_ch.valid        = 1'b0;
        req_ch.mode         = MODE_HELLO;
        req_ch.arrival_port = '0;
        req_ch.adv_root     = '0;
        req_ch.adv_path     = '0;
        req_ch.adv_sender   = '0;
        pkt_ch.ready        = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed: four neighbors, user port is 4 ----
        set_config(16'h0100, 5'd4);
        send_req(MODE_START, 5'd0, 16'h0000, 16'h0000, 16'h0000);
        // lower root wins outright
        send_req(MODE_HELLO, 5'd0, 16'h0050, 16'd3, 16'h0200);
        // same root, shorter path
        send_req(MODE_HELLO, 5'd1, 16'h0050, 16'd1, 16'h0300);
        // same root and path, lower sender takes over as parent
        send_req(MODE_HELLO, 5'd2, 16'h0050, 16'd1, 16'h0010);
        // no change; a neighbor at the same distance as this bridge is blocked
        send_req(MODE_HELLO, 5'd3, 16'h0050, 16'd2, 16'h0400);
        // no change, not parent, not child: blocked
        send_req(MODE_HELLO, 5'd0, 16'h0050, 16'd5, 16'h0200);
        // worse root with a saturating path
        send_req(MODE_HELLO, 5'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // hellos on the user port and beyond are dropped
        send_req(MODE_HELLO, 5'd4, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_HELLO, 5'd31, 16'h0000, 16'h0000, 16'h0000);
        // flood from a neighbor, from the user port and from nowhere
        send_req(MODE_FLOOD, 5'd1, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_FLOOD, 5'd4, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_FLOOD, 5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(MODE_UNUSED, 5'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // root 0 at a saturated distance
        send_req(MODE_HELLO, 5'd2, 16'h0000, 16'hFFFF, 16'h0000);
        // child test at distance 0xFFFF must not wrap: blocked
        send_req(MODE_HELLO, 5'd3, 16'h0000, 16'hFFFE, 16'h0005);
        // from the parent: open
        send_req(MODE_HELLO, 5'd0, 16'h0000, 16'hFFFF, 16'h0000);
        send_req(MODE_FLOOD, 5'd2, 16'h0000, 16'h0000, 16'h0000);

        // ---- directed: no neighbors at all ----
        drain();
        set_config(16'h5A5A, 5'd0);
        send_req(MODE_START, 5'd0, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_HELLO, 5'd0, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_FLOOD, 5'd0, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_FLOOD, 5'd7, 16'h0000, 16'h0000, 16'h0000);

        // ---- directed: port count above the maximum clamps to it ----
        drain();
        set_config(16'hFFFF, 5'd31);
        send_req(MODE_START, 5'd0, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_FLOOD, 5'd20, 16'h0000, 16'h0000, 16'h0000); // widest burst
        send_req(MODE_FLOOD, 5'd16, 16'h0000, 16'h0000, 16'h0000);
        send_req(MODE_HELLO, 5'd15, 16'h0000, 16'h0000, 16'hFFFF);
        send_req(MODE_FLOOD, 5'd3, 16'h0000, 16'h0000, 16'h0000);

        // ---- random phases, each under a fresh config ----
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            drain();
            if (phase == 0) begin
                own   = 16'h0000;
                ports = 5'd16;
            end else if (phase == 1) begin
                own   = 16'hFFFF;
                ports = 5'd1;
            end else begin
                own   = ADDR_BITS'($urandom);
                ports = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom_range(0, 31))
                                                    : PORT_W'($urandom_range(1, 16));
            end
            set_config(own, ports);
            root_pool[0] = own;
            root_pool[1] = own >> 1;
            root_pool[2] = ADDR_BITS'($urandom);
            foreach (sender_pool[i]) sender_pool[i] = ADDR_BITS'($urandom);
            calm = (phase == 2);   // one long stretch with no bubbles anywhere

            phase_base = counted;
            send_req(MODE_START, 5'd0, 16'h0000, 16'h0000, 16'h0000);
            while (counted - phase_base < PHASE_ITEMS) random_word();
            calm = 1'b0;
            phase++;
        end

        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
